// ===== hdl/tslps_pkg.sv =====
// Package with the shared types and constants of the transport / length packet splitter.
package tslps_pkg;

  localparam int unsigned POS_W = 17;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  localparam logic [7:0] TS_SYNC = 8'h47;
  localparam logic [7:0] LEN_SYNC1 = 8'h52;
  localparam logic [7:0] LEN_SYNC2 = 8'h9A;
  localparam logic [POS_W-1:0] LEN_HEADER = POS_W'(4);

  typedef enum logic [1:0] {
    KIND_DROP = 2'd0,
    KIND_TS   = 2'd1,
    KIND_LEN  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_HUNT = 2'd0,
    MODE_TS   = 2'd1,
    MODE_LEN  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    logic       packet_start;
    logic       packet_end;
    logic       ts_resync;
  } result_t;

  // One queue entry holds every result caused by one input word.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

endpackage

// ===== hdl/tslps_if.sv =====
// Valid/ready channel interfaces for the input bytes and the tagged result words.
interface tslps_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface tslps_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       packet_start;
  logic       packet_end;
  logic       ts_resync;
  logic       last_of_run;

  modport source (output valid, output out_byte, output kind, output packet_start,
                  output packet_end, output ts_resync, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input kind, input packet_start,
                input packet_end, input ts_resync, input last_of_run, output ready);
endinterface

// ===== hdl/tslps_front.sv =====
// Front end: sync tracking and classification of each input byte into a queue entry.
module tslps_front
  import tslps_pkg::*;
#(
  parameter int unsigned TS_PACKET_BYTES = 188
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  logic   [7:0] in_byte,
  output logic   in_ready,
  output logic   enq_valid,
  output entry_t enq_entry,
  input  logic   enq_ready
);

  localparam logic [POS_W-1:0] TS_LEN = POS_W'(TS_PACKET_BYTES);

  typedef struct packed {
    logic             emit;
    result_t          res;
    mode_t            mode;
    logic [POS_W-1:0] pos;
  } hunt_t;

  mode_t            mode, mode_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [15:0]      payload_length, payload_length_next;

  logic             accept;
  logic             any_result;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] len_total;
  logic [15:0]      len_full;
  logic             ts_end;
  hunt_t            h;

  // Out-of-sync examination of one byte.
  function automatic hunt_t hunt(input logic [7:0] b);
    hunt_t r;
    r = '0;
    r.mode = MODE_HUNT;
    r.pos = '0;
    if (b == TS_SYNC) begin
      r.emit = 1'b1;
      r.mode = MODE_TS;
      r.res = '{out_byte: b, kind: KIND_TS, packet_start: 1'b1,
                packet_end: (TS_PACKET_BYTES <= 1), ts_resync: 1'b1};
      r.pos = (TS_PACKET_BYTES > 1) ? POS_W'(1) : '0;
    end else if (b == LEN_SYNC1) begin
      r.mode = MODE_LEN;
      r.pos = POS_W'(1);
    end else begin
      r.emit = 1'b1;
      r.res = '{out_byte: b, kind: KIND_DROP, packet_start: 1'b0,
                packet_end: 1'b0, ts_resync: 1'b0};
    end
    return r;
  endfunction

  assign in_ready = enq_ready;
  assign accept = in_valid && enq_ready;
  assign enq_valid = accept && any_result;

  assign pos_inc = byte_position + POS_W'(1);
  assign len_total = LEN_HEADER + POS_W'(payload_length);
  assign len_full = {payload_length[15:8], in_byte};
  assign ts_end = (pos_inc >= TS_LEN);

  always_comb begin
    mode_next = mode;
    byte_position_next = byte_position;
    payload_length_next = payload_length;
    enq_entry = '0;
    any_result = 1'b0;
    h = hunt(in_byte);
    case (mode)
      MODE_TS: begin
        if (byte_position == '0 && in_byte != TS_SYNC) begin
          mode_next = h.mode;
          byte_position_next = h.pos;
          enq_entry.r0 = h.res;
          any_result = h.emit;
        end else begin
          enq_entry.r0 = '{out_byte: in_byte, kind: KIND_TS,
                           packet_start: (byte_position == '0),
                           packet_end: ts_end, ts_resync: 1'b0};
          any_result = 1'b1;
          byte_position_next = ts_end ? '0 : pos_inc;
        end
      end
      MODE_LEN: begin
        case (byte_position)
          POS_W'(0): begin
            if (in_byte == LEN_SYNC1) begin
              byte_position_next = POS_W'(1);
            end else begin
              mode_next = h.mode;
              byte_position_next = h.pos;
              enq_entry.r0 = h.res;
              any_result = h.emit;
            end
          end
          POS_W'(1): begin
            any_result = 1'b1;
            if (in_byte == LEN_SYNC2) begin
              enq_entry.two = 1'b1;
              enq_entry.r0 = '{out_byte: LEN_SYNC1, kind: KIND_LEN, packet_start: 1'b1,
                               packet_end: 1'b0, ts_resync: 1'b0};
              enq_entry.r1 = '{out_byte: in_byte, kind: KIND_LEN, packet_start: 1'b0,
                               packet_end: 1'b0, ts_resync: 1'b0};
              byte_position_next = POS_W'(2);
            end else begin
              // The held first sync byte is released as dropped.
              enq_entry.r0 = '{out_byte: LEN_SYNC1, kind: KIND_DROP, packet_start: 1'b0,
                               packet_end: 1'b0, ts_resync: 1'b0};
              enq_entry.two = h.emit;
              enq_entry.r1 = h.res;
              mode_next = h.mode;
              byte_position_next = h.pos;
            end
          end
          POS_W'(2): begin
            payload_length_next = {in_byte, 8'h00};
            enq_entry.r0 = '{out_byte: in_byte, kind: KIND_LEN, packet_start: 1'b0,
                             packet_end: 1'b0, ts_resync: 1'b0};
            any_result = 1'b1;
            byte_position_next = POS_W'(3);
          end
          POS_W'(3): begin
            payload_length_next = len_full;
            enq_entry.r0 = '{out_byte: in_byte, kind: KIND_LEN, packet_start: 1'b0,
                             packet_end: (len_full == '0), ts_resync: 1'b0};
            any_result = 1'b1;
            byte_position_next = (len_full == '0) ? '0 : LEN_HEADER;
          end
          default: begin
            enq_entry.r0 = '{out_byte: in_byte, kind: KIND_LEN, packet_start: 1'b0,
                             packet_end: (pos_inc >= len_total), ts_resync: 1'b0};
            any_result = 1'b1;
            byte_position_next = (pos_inc >= len_total) ? '0 : pos_inc;
          end
        endcase
      end
      default: begin
        mode_next = h.mode;
        byte_position_next = h.pos;
        enq_entry.r0 = h.res;
        any_result = h.emit;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_HUNT;
      byte_position <= '0;
      payload_length <= '0;
    end else if (accept) begin
      mode <= mode_next;
      byte_position <= byte_position_next;
      payload_length <= payload_length_next;
    end
  end

endmodule

// ===== hdl/tslps_queue.sv =====
// Short register queue of classified entries between the front and back ends.
module tslps_queue
  import tslps_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   enq_valid,
  input  entry_t enq_entry,
  output logic   enq_ready,
  output logic   deq_valid,
  output entry_t deq_entry,
  input  logic   deq_pop
);

  entry_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign enq_ready = (count < Q_CNT_W'(Q_DEPTH));
  assign deq_valid = (count != '0);
  assign deq_entry = slots[rd_ptr];
  assign do_push = enq_valid && enq_ready;
  assign do_pop = deq_pop && deq_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= enq_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/tslps_back.sv =====
// Back end: unpacks queue entries into result words through an output register.
module tslps_back
  import tslps_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   head_valid,
  input  entry_t head_entry,
  output logic   head_pop,
  tslps_result_if.source res
);

  logic    phase;
  logic    out_valid;
  result_t out_res;
  logic    out_last;
  logic    load;
  logic    first_of_two;

  assign load = head_valid && (!out_valid || res.ready);
  assign first_of_two = head_entry.two && !phase;
  assign head_pop = load && !first_of_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase <= first_of_two;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= phase ? head_entry.r1 : head_entry.r0;
      out_last <= !first_of_two;
    end
  end

  assign res.valid = out_valid;
  assign res.out_byte = out_res.out_byte;
  assign res.kind = out_res.kind;
  assign res.packet_start = out_res.packet_start;
  assign res.packet_end = out_res.packet_end;
  assign res.ts_resync = out_res.ts_resync;
  assign res.last_of_run = out_last;

endmodule

// ===== hdl/ts_and_length_packet_splitter_top.sv =====
// Top level of the transport / length-prefixed packet splitter.
// Results of an accepted word pass through a four-entry queue and the output register.
// Throughput: one input word per cycle while the queue has room; a byte that releases
// a held sync byte makes two result words (one if it is held anew), sent in turn.
// Reset (synchronous, rst high): hunting for sync, nothing held, queue and output empty.
module ts_and_length_packet_splitter_top
  import tslps_pkg::*;
#(
  parameter int unsigned TS_PACKET_BYTES = 188
) (
  input logic clk,
  input logic rst,
  tslps_byte_if.sink byte_in,
  tslps_result_if.source result_out
);

  // The front end follows the packet structure and turns each accepted byte into
  // zero, one or two tagged results. A byte with no result (a held first sync of a
  // length packet) never enters the queue.
  logic   enq_valid;
  logic   enq_ready;
  entry_t enq_entry;

  // The back end drains the queue one result word per cycle, while the sink is ready, into
  // its output register, so the front keeps taking bytes while a result waits for the sink.
  logic   head_valid;
  logic   head_pop;
  entry_t head_entry;

  tslps_front #(
    .TS_PACKET_BYTES(TS_PACKET_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_in.valid),
    .in_byte  (byte_in.data_byte),
    .in_ready (byte_in.ready),
    .enq_valid(enq_valid),
    .enq_entry(enq_entry),
    .enq_ready(enq_ready)
  );

  tslps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .enq_valid(enq_valid),
    .enq_entry(enq_entry),
    .enq_ready(enq_ready),
    .deq_valid(head_valid),
    .deq_entry(head_entry),
    .deq_pop  (head_pop)
  );

  tslps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_entry(head_entry),
    .head_pop  (head_pop),
    .res       (result_out)
  );

endmodule
